[rtl/dlist_pkg.sv]
package dlist_pkg;

    // Defaults for the top-level parameters
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed field widths of the request and response
    localparam int CMD_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 5;

    // Request command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_SEARCH     = 3'd4,
        CMD_DUMP       = 3'd5
    } cmd_t;

    // Response status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SREAD,
        S_SCHECK,
        S_DREAD,
        S_DEMIT
    } state_t;

    // Datapath pointer operations
    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_POP_FRONT,
        OP_POP_BACK,
        OP_SCAN_START,
        OP_SCAN_STEP
    } dp_op_t;

    // Kind of response to load into the output register
    typedef enum logic [1:0] {
        RES_NONE,
        RES_STATUS,
        RES_POS,
        RES_ELEM
    } res_t;

    // Controller to datapath commands
    typedef struct packed {
        dp_op_t  op;
        logic    rd_en;
        res_t    res;
        status_t status;
        logic    last;
    } dl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic empty;
        logic full;
        logic match;
        logic at_end;
        logic out_free;
    } dl_stat_t;

endpackage

[rtl/dlist_if.sv]
interface dlist_req_if;
    logic                                valid;
    logic                                ready;
    logic [dlist_pkg::CMD_W-1:0]         cmd;
    logic signed [dlist_pkg::VALUE_W-1:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface dlist_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic [dlist_pkg::STATUS_W-1:0]       status;
    logic signed [dlist_pkg::VALUE_W-1:0] element;
    logic [dlist_pkg::POS_W-1:0]          position;
    logic                                 last;

    modport source (output valid, output status, output element, output position,
                    output last, input ready);
    modport sink   (input valid, input status, input element, input position,
                    input last, output ready);
endinterface

[rtl/dlist_ctrl.sv]
module dlist_ctrl
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    input  logic [dlist_pkg::CMD_W-1:0] req_cmd,
    output logic                        req_ready,
    input  dlist_pkg::dl_stat_t         stat,
    output dlist_pkg::dl_cmd_t          cmd
);

    dlist_pkg::state_t state_reg;
    dlist_pkg::state_t state_next;

    // Hold the state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dlist_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Decode requests and sequence scans
    always_comb
    begin
        state_next = state_reg;
        req_ready  = 1'b0;
        cmd.op     = dlist_pkg::OP_NONE;
        cmd.rd_en  = 1'b0;
        cmd.res    = dlist_pkg::RES_NONE;
        cmd.status = dlist_pkg::ST_OK;
        cmd.last   = 1'b1;

        unique case (state_reg)
            dlist_pkg::S_IDLE:
            begin
                req_ready = stat.out_free;
                if (req_valid && stat.out_free)
                begin
                    cmd.res = dlist_pkg::RES_STATUS;
                    case (dlist_pkg::cmd_t'(req_cmd))
                        dlist_pkg::CMD_PUSH_FRONT:
                        begin
                            if (stat.full)
                            begin
                                cmd.status = dlist_pkg::ST_OVERFLOW;
                            end
                            else
                            begin
                                cmd.op = dlist_pkg::OP_PUSH_FRONT;
                            end
                        end
                        dlist_pkg::CMD_PUSH_BACK:
                        begin
                            if (stat.full)
                            begin
                                cmd.status = dlist_pkg::ST_OVERFLOW;
                            end
                            else
                            begin
                                cmd.op = dlist_pkg::OP_PUSH_BACK;
                            end
                        end
                        dlist_pkg::CMD_POP_FRONT:
                        begin
                            if (stat.empty)
                            begin
                                cmd.status = dlist_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                cmd.op = dlist_pkg::OP_POP_FRONT;
                            end
                        end
                        dlist_pkg::CMD_POP_BACK:
                        begin
                            if (stat.empty)
                            begin
                                cmd.status = dlist_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                cmd.op = dlist_pkg::OP_POP_BACK;
                            end
                        end
                        dlist_pkg::CMD_SEARCH:
                        begin
                            if (stat.empty)
                            begin
                                cmd.status = dlist_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                cmd.res    = dlist_pkg::RES_NONE;
                                cmd.op     = dlist_pkg::OP_SCAN_START;
                                state_next = dlist_pkg::S_SREAD;
                            end
                        end
                        dlist_pkg::CMD_DUMP:
                        begin
                            if (stat.empty)
                            begin
                                cmd.status = dlist_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                cmd.res    = dlist_pkg::RES_NONE;
                                cmd.op     = dlist_pkg::OP_SCAN_START;
                                state_next = dlist_pkg::S_DREAD;
                            end
                        end
                        default:
                        begin
                            cmd.status = dlist_pkg::ST_OK;
                        end
                    endcase
                end
            end
            dlist_pkg::S_SREAD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = dlist_pkg::S_SCHECK;
            end
            dlist_pkg::S_SCHECK:
            begin
                if (stat.match)
                begin
                    if (stat.out_free)
                    begin
                        cmd.res    = dlist_pkg::RES_POS;
                        state_next = dlist_pkg::S_IDLE;
                    end
                end
                else if (stat.at_end)
                begin
                    if (stat.out_free)
                    begin
                        cmd.res    = dlist_pkg::RES_STATUS;
                        cmd.status = dlist_pkg::ST_NOTFOUND;
                        state_next = dlist_pkg::S_IDLE;
                    end
                end
                else
                begin
                    cmd.op     = dlist_pkg::OP_SCAN_STEP;
                    state_next = dlist_pkg::S_SREAD;
                end
            end
            dlist_pkg::S_DREAD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = dlist_pkg::S_DEMIT;
            end
            dlist_pkg::S_DEMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.res  = dlist_pkg::RES_ELEM;
                    cmd.last = stat.at_end;
                    if (stat.at_end)
                    begin
                        state_next = dlist_pkg::S_IDLE;
                    end
                    else
                    begin
                        cmd.op     = dlist_pkg::OP_SCAN_STEP;
                        state_next = dlist_pkg::S_DREAD;
                    end
                end
            end
            default:
            begin
                state_next = dlist_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[rtl/dlist_dp.sv]
module dlist_dp
#(
    parameter int DEPTH      = dlist_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dlist_pkg::DATA_WIDTH_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  dlist_pkg::dl_cmd_t                   cmd,
    output dlist_pkg::dl_stat_t                  stat,
    input  logic signed [dlist_pkg::VALUE_W-1:0] value,
    dlist_rsp_if.source                          rsp
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int VW = dlist_pkg::VALUE_W;
    localparam int PW = dlist_pkg::POS_W;

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    logic [IW-1:0]         front_reg;
    logic [CW-1:0]         count_reg;
    logic [IW-1:0]         sp_reg;
    logic [CW-1:0]         idx_reg;
    logic [DATA_WIDTH-1:0] key_reg;
    logic [DATA_WIDTH-1:0] rd_data_reg;

    logic                  out_valid_reg;
    dlist_pkg::status_t    status_reg;
    logic [VW-1:0]         element_reg;
    logic [PW-1:0]         position_reg;
    logic                  last_reg;

    logic [DATA_WIDTH-1:0] value_m;
    logic [VW-1:0]         elem_w;
    logic [PW-1:0]         pos_w;
    logic [CW-1:0]         idx_plus;
    logic [IW-1:0]         front_dec;
    logic [IW-1:0]         front_inc;
    logic [IW-1:0]         sp_inc;
    logic [IW:0]           tail_sum;
    logic [IW-1:0]         tail_idx;
    logic                  out_free;

    // Fit the request value and stored data to the field widths
    generate
        if (DATA_WIDTH == VW)
        begin : g_equal
            assign value_m = value;
            assign elem_w  = rd_data_reg;
        end
        else if (DATA_WIDTH < VW)
        begin : g_narrow
            assign value_m = value[DATA_WIDTH-1:0];
            assign elem_w  = {{(VW - DATA_WIDTH){1'b0}}, rd_data_reg};
        end
        else
        begin : g_wide
            assign value_m = {{(DATA_WIDTH - VW){1'b0}}, value};
            assign elem_w  = rd_data_reg[VW-1:0];
        end
    endgenerate

    // Position wraps to the field width
    assign idx_plus = idx_reg + 1'b1;
    generate
        if (CW >= PW)
        begin : g_pos_trunc
            assign pos_w = idx_plus[PW-1:0];
        end
        else
        begin : g_pos_ext
            assign pos_w = {{(PW - CW){1'b0}}, idx_plus};
        end
    endgenerate

    // Ring index arithmetic
    assign front_dec = (front_reg == '0) ? IW'(DEPTH - 1) : front_reg - 1'b1;
    assign front_inc = (front_reg == IW'(DEPTH - 1)) ? '0 : front_reg + 1'b1;
    assign sp_inc    = (sp_reg == IW'(DEPTH - 1)) ? '0 : sp_reg + 1'b1;
    assign tail_sum  = {1'b0, front_reg} + (IW + 1)'(count_reg);
    always_comb
    begin
        if (tail_sum >= (IW + 1)'(DEPTH))
        begin
            tail_idx = IW'(tail_sum - (IW + 1)'(DEPTH));
        end
        else
        begin
            tail_idx = tail_sum[IW-1:0];
        end
    end

    // Report status to the controller
    assign out_free      = !out_valid_reg || rsp.ready;
    assign stat.empty    = (count_reg == '0);
    assign stat.full     = (count_reg == CW'(DEPTH));
    assign stat.match    = (rd_data_reg == key_reg);
    assign stat.at_end   = (idx_plus == count_reg);
    assign stat.out_free = out_free;

    // Advance the list pointers and scan pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
            sp_reg    <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            case (cmd.op)
                dlist_pkg::OP_PUSH_FRONT:
                begin
                    front_reg <= front_dec;
                    count_reg <= count_reg + 1'b1;
                end
                dlist_pkg::OP_PUSH_BACK:
                begin
                    count_reg <= count_reg + 1'b1;
                end
                dlist_pkg::OP_POP_FRONT:
                begin
                    front_reg <= front_inc;
                    count_reg <= count_reg - 1'b1;
                end
                dlist_pkg::OP_POP_BACK:
                begin
                    count_reg <= count_reg - 1'b1;
                end
                dlist_pkg::OP_SCAN_START:
                begin
                    sp_reg  <= front_reg;
                    idx_reg <= '0;
                end
                dlist_pkg::OP_SCAN_STEP:
                begin
                    sp_reg  <= sp_inc;
                    idx_reg <= idx_plus;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Latch the search key
    always_ff @(posedge clk)
    begin
        if (cmd.op == dlist_pkg::OP_SCAN_START)
        begin
            key_reg <= value_m;
        end
    end

    // Write the element store and register its read port
    always_ff @(posedge clk)
    begin
        if (cmd.op == dlist_pkg::OP_PUSH_FRONT)
        begin
            mem[front_dec] <= value_m;
        end
        else if (cmd.op == dlist_pkg::OP_PUSH_BACK)
        begin
            mem[tail_idx] <= value_m;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[sp_reg];
        end
    end

    // Hold the response valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.res != dlist_pkg::RES_NONE)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load the response payload
    always_ff @(posedge clk)
    begin
        case (cmd.res)
            dlist_pkg::RES_STATUS:
            begin
                status_reg   <= cmd.status;
                element_reg  <= '0;
                position_reg <= '0;
                last_reg     <= 1'b1;
            end
            dlist_pkg::RES_POS:
            begin
                status_reg   <= dlist_pkg::ST_OK;
                element_reg  <= '0;
                position_reg <= pos_w;
                last_reg     <= 1'b1;
            end
            dlist_pkg::RES_ELEM:
            begin
                status_reg   <= dlist_pkg::ST_OK;
                element_reg  <= elem_w;
                position_reg <= '0;
                last_reg     <= cmd.last;
            end
            default:
            begin
            end
        endcase
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.status   = status_reg;
    assign rsp.element  = element_reg;
    assign rsp.position = position_reg;
    assign rsp.last     = last_reg;

endmodule

[rtl/double_ended_list_with_search.sv]
// Push, pop, empty-list and unused commands respond in the cycle after the request.
// Search: each element scanned takes a registered store read (SREAD), then a compare (SCHECK).
// Dump: per element, a store read (DREAD), then an emit (DEMIT) held by backpressure.
// A new request is taken once the previous command has loaded its final response
// and the response register is empty or being taken in the same cycle.
// Reset (async, active low) empties the list and clears control; the store is not cleared.
module double_ended_list_with_search
#(
    parameter int DEPTH      = dlist_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dlist_pkg::DATA_WIDTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    dlist_req_if.sink req,
    dlist_rsp_if.source rsp
);

    dlist_pkg::dl_cmd_t  cmd;
    dlist_pkg::dl_stat_t stat;

    // Sequence commands
    dlist_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_cmd   (req.cmd),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Hold the list and the response register
    dlist_dp
    #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    )
    u_dp
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat),
        .value (req.value),
        .rsp   (rsp)
    );

endmodule
